/* design/pulse_leader_tone_detector_core_defines.svh */
// Assertion macros shared by the checker of the leader tone detector.
`ifndef PULSE_LEADER_TONE_DETECTOR_CORE_DEFINES_SVH
`define PULSE_LEADER_TONE_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define PLTD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pltd assertion failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define PLTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pltd assertion failed");

`endif

/* design/pltd_pkg.sv */
// Shared types and constants of the leader tone detector.
package pltd_pkg;

	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 20;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_LEADER = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOLERANCE  = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUANT      = 2'd2;

	localparam logic [15:0] MIN_LEADER_RESET = 16'd100;
	localparam logic [15:0] TOLERANCE_RESET  = 16'd6554;
	localparam logic [19:0] QUANT_RESET      = 20'd363;

	typedef struct packed {
		logic [15:0] leader_min_len;
		logic [15:0] tolerance_fraction;
		logic [19:0] quant_floor;
	} cfg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_TEST,
		F_UPD
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_NS,
		B_TT,
		B_SUB,
		B_SQRT,
		B_DAVG,
		B_DDEV,
		B_DONE
	} back_state_t;

endpackage

/* design/pulse_leader_tone_detector_core.sv */
// Top level of the leader tone detector: configuration registers, front, queue and back.
//
//  channel  | handshake            | beat contents
//  ---------+----------------------+--------------------------------------------------
//  pulse in | push / full          | pulse_duration, last_pulse
//  result   | empty / pop          | leader_first, leader_len, average/minimum/maximum
//           |                      | period, deviation
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// In the front a pulse beat passes latch, products, difference and tolerance product, and
// run update; full is high from the products step until the run update is done.
// In the back a closed leader passes load, shift-add n*S and T*T, clamp, digit square
// root, two divisions and hand-off.
// The front stalls in its update cycle only when it must hand a leader over and the
// two-entry run queue is full; the back stalls only on an unpopped result.
// Reset clears the run, the pulse index and all handshake state; config takes its defaults.
module pulse_leader_tone_detector_core #(
	parameter int DURATION_WIDTH = 20,
	parameter int INDEX_WIDTH    = 32,
	parameter int COUNT_WIDTH    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [DURATION_WIDTH-1:0]            pulse_duration,
	input  logic                                 last_pulse,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [INDEX_WIDTH-1:0]               leader_first,
	output logic [COUNT_WIDTH-1:0]               leader_len,
	output logic [DURATION_WIDTH-1:0]            average_period,
	output logic [DURATION_WIDTH-1:0]            minimum_period,
	output logic [DURATION_WIDTH-1:0]            maximum_period,
	output logic [DURATION_WIDTH-1:0]            deviation,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pltd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [pltd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	localparam int SNW = INDEX_WIDTH + COUNT_WIDTH + 2 * (DURATION_WIDTH + COUNT_WIDTH)
	                     + 3 * DURATION_WIDTH;

	pltd_pkg::cfg_t cfg_q;
	logic           q_wr, q_rd, q_full, q_empty;
	logic [SNW-1:0] q_wdata, q_rdata;

	// Config writes are always taken; writes beyond the register list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_min_len     <= pltd_pkg::MIN_LEADER_RESET;
			cfg_q.tolerance_fraction <= pltd_pkg::TOLERANCE_RESET;
			cfg_q.quant_floor        <= pltd_pkg::QUANT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				pltd_pkg::CFG_MIN_LEADER: cfg_q.leader_min_len     <= cfg_data[15:0];
				pltd_pkg::CFG_TOLERANCE:  cfg_q.tolerance_fraction <= cfg_data[15:0];
				pltd_pkg::CFG_QUANT:      cfg_q.quant_floor        <= cfg_data[19:0];
				default: begin
				end
			endcase
		end
	end

	// Front: similarity test and run bookkeeping, one pulse at a time.
	pltd_front #(
		.DURATION_WIDTH(DURATION_WIDTH),
		.INDEX_WIDTH   (INDEX_WIDTH),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.pulse_duration(pulse_duration),
		.last_pulse    (last_pulse),
		.cfg           (cfg_q),
		.q_full        (q_full),
		.q_wr          (q_wr),
		.q_data        (q_wdata)
	);

	// Queue of closed leaders: decouples pulse intake from the long statistics pass.
	pltd_queue #(
		.WIDTH(SNW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wr_data(q_wdata),
		.full   (q_full),
		.rd_en  (q_rd),
		.rd_data(q_rdata),
		.empty  (q_empty)
	);

	// Back: average, deviation and the result register.
	pltd_back #(
		.DURATION_WIDTH(DURATION_WIDTH),
		.INDEX_WIDTH   (INDEX_WIDTH),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_rd          (q_rd),
		.q_data        (q_rdata),
		.empty         (empty),
		.pop           (pop),
		.leader_first  (leader_first),
		.leader_len    (leader_len),
		.average_period(average_period),
		.minimum_period(minimum_period),
		.maximum_period(maximum_period),
		.deviation     (deviation)
	);

endmodule

/* design/pltd_front.sv */
// Front part: accepts pulses, runs the similarity test and tracks the open run.
module pltd_front #(
	parameter int DURATION_WIDTH = 20,
	parameter int INDEX_WIDTH    = 32,
	parameter int COUNT_WIDTH    = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [DURATION_WIDTH-1:0] pulse_duration,
	input  logic                      last_pulse,
	input  pltd_pkg::cfg_t            cfg,
	input  logic                      q_full,
	output logic                      q_wr,
	output logic [INDEX_WIDTH+COUNT_WIDTH+2*(DURATION_WIDTH+COUNT_WIDTH)
	              +3*DURATION_WIDTH-1:0] q_data
);
	localparam int DW  = DURATION_WIDTH;
	localparam int CW  = COUNT_WIDTH;
	localparam int IW  = INDEX_WIDTH;
	localparam int TW  = DW + CW;
	localparam int SW  = 2 * DW + CW;
	localparam int DDW = 2 * DW;
	localparam int QW  = 20 + CW;
	localparam int RLW = TW + 17;
	localparam int AW  = (TW > QW) ? TW : QW;
	localparam int MW  = (CW > 16) ? CW : 16;
	localparam logic [CW-1:0] CMAX = {CW{1'b1}};

	pltd_pkg::front_state_t st_q, st_d;

	logic [DW-1:0]  d_q;
	logic           last_q;
	logic [TW-1:0]  dn_s1;
	logic [DDW-1:0] dd_s1;
	logic [QW-1:0]  qfn_s1;
	logic [TW-1:0]  a_s2;
	logic [RLW-1:0] rel_s2;

	logic [TW-1:0] tot_q;
	logic [SW-1:0] sq_q;
	logic [CW-1:0] len_q;
	logic [IW-1:0] first_q;
	logic [DW-1:0] short_q;
	logic [DW-1:0] long_q;
	logic [IW-1:0] idx_q;

	logic [16:0]   teff;
	logic [15:0]   mmin;
	logic          fits, opened, join_run, fail, emit, stall, upd;
	logic [TW-1:0] j_tot;
	logic [SW-1:0] j_sq;
	logic [CW-1:0] j_len;
	logic [DW-1:0] j_short, j_long;

	assign mmin = (cfg.leader_min_len < 16'd2) ? 16'd2 : cfg.leader_min_len;
	assign teff = (MW'(len_q) < MW'(cfg.leader_min_len)) ?
		{cfg.tolerance_fraction, 1'b0} : {1'b0, cfg.tolerance_fraction};

	assign fits = (RLW'({a_s2, 16'h0000}) <= rel_s2) || (AW'(a_s2) <= AW'(qfn_s1));
	assign opened   = (len_q == '0);
	assign join_run = !opened && fits;
	assign fail     = !opened && !fits;

	assign j_tot   = tot_q + TW'(d_q);
	assign j_sq    = sq_q + SW'(dd_s1);
	assign j_len   = len_q + CW'(1);
	assign j_short = (d_q < short_q) ? d_q : short_q;
	assign j_long  = (d_q > long_q) ? d_q : long_q;

	always_comb begin
		emit = 1'b0;
		if (join_run) begin
			emit = ((j_len == CMAX) || last_q) && (MW'(j_len) >= MW'(mmin));
		end else if (fail) begin
			emit = (MW'(len_q) >= MW'(mmin));
		end
	end

	assign q_data = fail ? {first_q, len_q, tot_q, sq_q, short_q, long_q}
	                     : {first_q, j_len, j_tot, j_sq, j_short, j_long};

	always_comb begin
		st_d = st_q;
		case (st_q)
			pltd_pkg::F_IDLE: if (push) st_d = pltd_pkg::F_MUL;
			pltd_pkg::F_MUL:  st_d = pltd_pkg::F_TEST;
			pltd_pkg::F_TEST: st_d = pltd_pkg::F_UPD;
			pltd_pkg::F_UPD:  if (!stall) st_d = pltd_pkg::F_IDLE;
			default:          st_d = pltd_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		full  = (st_q != pltd_pkg::F_IDLE);
		stall = emit && q_full;
		upd   = (st_q == pltd_pkg::F_UPD) && !stall;
		q_wr  = upd && emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pltd_pkg::F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Stage registers: operands and products of the similarity test.
	always_ff @(posedge clk) begin
		if (st_q == pltd_pkg::F_IDLE && push) begin
			d_q    <= pulse_duration;
			last_q <= last_pulse;
		end
		if (st_q == pltd_pkg::F_MUL) begin
			dn_s1  <= TW'(d_q) * TW'(len_q);
			dd_s1  <= DDW'(d_q) * DDW'(d_q);
			qfn_s1 <= QW'(cfg.quant_floor) * QW'(len_q);
		end
		if (st_q == pltd_pkg::F_TEST) begin
			a_s2   <= (dn_s1 >= tot_q) ? (dn_s1 - tot_q) : (tot_q - dn_s1);
			rel_s2 <= RLW'(tot_q) * RLW'(teff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q   <= '0;
			sq_q    <= '0;
			len_q   <= '0;
			first_q <= '0;
			short_q <= '1;
			long_q  <= '0;
			idx_q   <= '0;
		end else if (upd) begin
			if (last_q || (join_run && j_len == CMAX)) begin
				// drop the run: closed by the cap or by the end of the recording
				tot_q   <= '0;
				sq_q    <= '0;
				len_q   <= '0;
				first_q <= '0;
				short_q <= '1;
				long_q  <= '0;
			end else if (join_run) begin
				tot_q   <= j_tot;
				sq_q    <= j_sq;
				len_q   <= j_len;
				short_q <= j_short;
				long_q  <= j_long;
			end else begin
				tot_q   <= TW'(d_q);
				sq_q    <= SW'(dd_s1);
				len_q   <= CW'(1);
				first_q <= idx_q;
				short_q <= d_q;
				long_q  <= d_q;
			end
			idx_q <= last_q ? '0 : idx_q + IW'(1);
		end
	end

endmodule

/* design/pltd_queue.sv */
// Two-entry queue of closed runs between the front and back parts.
module pltd_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

/* design/pltd_back.sv */
// Back part: statistics of a closed run by shift-add, digit square root and division.
module pltd_back #(
	parameter int DURATION_WIDTH = 20,
	parameter int INDEX_WIDTH    = 32,
	parameter int COUNT_WIDTH    = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	output logic                      q_rd,
	input  logic [INDEX_WIDTH+COUNT_WIDTH+2*(DURATION_WIDTH+COUNT_WIDTH)
	              +3*DURATION_WIDTH-1:0] q_data,
	output logic                      empty,
	input  logic                      pop,
	output logic [INDEX_WIDTH-1:0]    leader_first,
	output logic [COUNT_WIDTH-1:0]    leader_len,
	output logic [DURATION_WIDTH-1:0] average_period,
	output logic [DURATION_WIDTH-1:0] minimum_period,
	output logic [DURATION_WIDTH-1:0] maximum_period,
	output logic [DURATION_WIDTH-1:0] deviation
);
	localparam int DW   = DURATION_WIDTH;
	localparam int CW   = COUNT_WIDTH;
	localparam int IW   = INDEX_WIDTH;
	localparam int TW   = DW + CW;
	localparam int SW   = 2 * DW + CW;
	localparam int RW   = TW;
	localparam int NSW  = 2 * RW;
	localparam int SRW  = RW + 2;
	localparam int CNTW = $clog2(RW + 1);
	localparam int O_S  = 2 * DW;
	localparam int O_T  = O_S + SW;
	localparam int O_N  = O_T + TW;
	localparam int O_I  = O_N + CW;

	pltd_pkg::back_state_t st_q, st_d;

	logic [IW-1:0]   j_first;
	logic [CW-1:0]   j_n;
	logic [TW-1:0]   j_t;
	logic [SW-1:0]   j_s;
	logic [DW-1:0]   j_mn, j_mx;
	logic [CNTW-1:0] cnt_q;
	logic [TW-1:0]   msh_q;
	logic [NSW-1:0]  acc_q, ns_q;
	logic [SRW-1:0]  srem_q;
	logic [RW-1:0]   root_q;
	logic [RW-1:0]   dq_q;
	logic [CW-1:0]   drem_q;
	logic [DW-1:0]   avg_q, dev_q;
	logic            res_valid_q;
	logic            last_step, load_out;

	logic [NSW-1:0]   addend, acc_next;
	logic [SRW+1:0]   rem2, trial;
	logic             sge;
	logic [SRW-1:0]   srem_next;
	logic [RW-1:0]    root_next;
	logic [CW:0]      r2, rnext;
	logic             dge;
	logic [RW-1:0]    dq_next;

	// Shift-add multiply step: one bit of the multiplier per cycle, MSB first.
	always_comb begin
		addend = '0;
		if (msh_q[TW-1]) addend = (st_q == pltd_pkg::B_NS) ? NSW'(j_s) : NSW'(j_t);
	end
	assign acc_next = {acc_q[NSW-2:0], 1'b0} + addend;

	// Restoring square root: two radicand bits per cycle.
	assign rem2      = {srem_q, ns_q[NSW-1 -: 2]};
	assign trial     = (SRW+2)'({root_q, 2'b01});
	assign sge       = (rem2 >= trial);
	assign srem_next = SRW'(sge ? rem2 - trial : rem2);
	assign root_next = {root_q[RW-2:0], sge};

	// Restoring division by the pulse count: one quotient bit per cycle.
	assign r2      = {drem_q, dq_q[RW-1]};
	assign dge     = (r2 >= {1'b0, j_n});
	assign rnext   = dge ? r2 - {1'b0, j_n} : r2;
	assign dq_next = {dq_q[RW-2:0], dge};

	assign last_step = (cnt_q == CNTW'(1));

	always_comb begin
		st_d = st_q;
		case (st_q)
			pltd_pkg::B_IDLE: if (!q_empty) st_d = pltd_pkg::B_NS;
			pltd_pkg::B_NS:   if (last_step) st_d = pltd_pkg::B_TT;
			pltd_pkg::B_TT:   if (last_step) st_d = pltd_pkg::B_SUB;
			pltd_pkg::B_SUB:  st_d = pltd_pkg::B_SQRT;
			pltd_pkg::B_SQRT: if (last_step) st_d = pltd_pkg::B_DAVG;
			pltd_pkg::B_DAVG: if (last_step) st_d = pltd_pkg::B_DDEV;
			pltd_pkg::B_DDEV: if (last_step) st_d = pltd_pkg::B_DONE;
			pltd_pkg::B_DONE: if (!res_valid_q || pop) st_d = pltd_pkg::B_IDLE;
			default:          st_d = pltd_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_rd     = (st_q == pltd_pkg::B_IDLE) && !q_empty;
		load_out = (st_q == pltd_pkg::B_DONE) && (!res_valid_q || pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= pltd_pkg::B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_out) res_valid_q <= 1'b1;
			else if (pop) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			pltd_pkg::B_IDLE: begin
				if (!q_empty) begin
					j_first <= q_data[O_I +: IW];
					j_n     <= q_data[O_N +: CW];
					j_t     <= q_data[O_T +: TW];
					j_s     <= q_data[O_S +: SW];
					j_mn    <= q_data[DW +: DW];
					j_mx    <= q_data[0 +: DW];
					msh_q   <= {q_data[O_N +: CW], {DW{1'b0}}};
					acc_q   <= '0;
					cnt_q   <= CNTW'(CW);
				end
			end
			pltd_pkg::B_NS: begin
				if (last_step) begin
					ns_q  <= acc_next;
					acc_q <= '0;
					msh_q <= j_t;
					cnt_q <= CNTW'(TW);
				end else begin
					cnt_q <= cnt_q - CNTW'(1);
					msh_q <= {msh_q[TW-2:0], 1'b0};
					acc_q <= acc_next;
				end
			end
			pltd_pkg::B_TT: begin
				cnt_q <= cnt_q - CNTW'(1);
				msh_q <= {msh_q[TW-2:0], 1'b0};
				acc_q <= acc_next;
			end
			pltd_pkg::B_SUB: begin
				// clamp n*S - T*T at zero
				ns_q   <= (ns_q >= acc_q) ? ns_q - acc_q : '0;
				srem_q <= '0;
				root_q <= '0;
				cnt_q  <= CNTW'(RW);
			end
			pltd_pkg::B_SQRT: begin
				ns_q   <= {ns_q[NSW-3:0], 2'b00};
				srem_q <= srem_next;
				root_q <= root_next;
				if (last_step) begin
					dq_q   <= j_t;
					drem_q <= '0;
					cnt_q  <= CNTW'(RW);
				end else begin
					cnt_q  <= cnt_q - CNTW'(1);
				end
			end
			pltd_pkg::B_DAVG: begin
				if (last_step) begin
					avg_q  <= DW'(dq_next);
					dq_q   <= root_q;
					drem_q <= '0;
					cnt_q  <= CNTW'(RW);
				end else begin
					cnt_q  <= cnt_q - CNTW'(1);
					dq_q   <= dq_next;
					drem_q <= CW'(rnext);
				end
			end
			pltd_pkg::B_DDEV: begin
				cnt_q  <= cnt_q - CNTW'(1);
				dq_q   <= dq_next;
				drem_q <= CW'(rnext);
				if (last_step) dev_q <= DW'(dq_next);
			end
			default: begin
			end
		endcase
	end

	// Result register: holds the oldest result until it is popped.
	always_ff @(posedge clk) begin
		if (load_out) begin
			leader_first   <= j_first;
			leader_len     <= j_n;
			average_period <= avg_q;
			minimum_period <= j_mn;
			maximum_period <= j_mx;
			deviation      <= dev_q;
		end
	end

	assign empty = !res_valid_q;

endmodule

/* design/pltd_checker.sv */
// Port-level checker of the leader tone detector and its bind.
`include "pulse_leader_tone_detector_core_defines.svh"

module pltd_checker #(
	parameter int DURATION_WIDTH = 20,
	parameter int COUNT_WIDTH    = 16
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      push,
	input logic                      full,
	input logic                      empty,
	input logic                      pop,
	input logic [COUNT_WIDTH-1:0]    leader_len,
	input logic [DURATION_WIDTH-1:0] average_period,
	input logic [DURATION_WIDTH-1:0] minimum_period,
	input logic [DURATION_WIDTH-1:0] maximum_period
);
	// hold a result that was not popped
	`PLTD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)
	// a leader always has at least two pulses
	`PLTD_ASSERT_NOW(a_count_min, !empty, leader_len >= COUNT_WIDTH'(2))
	// the average lies between the shortest and the longest pulse
	`PLTD_ASSERT_NOW(a_avg_range, !empty,
		minimum_period <= average_period && average_period <= maximum_period)
	// the front is busy for the cycle after it takes a pulse
	`PLTD_ASSERT_NEXT(a_front_busy, push && !full, full)

endmodule

bind pulse_leader_tone_detector_core pltd_checker #(
	.DURATION_WIDTH(DURATION_WIDTH),
	.COUNT_WIDTH   (COUNT_WIDTH)
) u_pltd_checker (.*);
